[src/ptb_pkg.sv]
package ptb_pkg;

    localparam int NUM_TIMERS  = 8;
    localparam int TICK_WIDTH  = 32;
    localparam int IDX_W       = 3;
    localparam int ACTION_W    = 3;
    localparam int LIMIT_W     = 33;
    localparam int ELAPSED_W   = 32;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 40;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = 2;

    localparam logic [ACTION_W-1:0] ACT_TICK      = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_START     = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_STOP      = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_START_ALL = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_STOP_ALL  = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_PAUSE     = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_RESUME    = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_QUERY     = 3'd7;

    typedef logic [TICK_WIDTH-1:0] tick_t;
    typedef logic [LIMIT_W-1:0]    limit_t;

    // One decoded command as it travels from the front to the back.
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [IDX_W-1:0]    idx;
    } cmd_t;

    // Handshake between a producer and a consumer of commands.
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_beat_t;

endpackage

[src/ptb_front.sv]
module ptb_front (
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [ptb_pkg::IN_DATA_W-1:0] s_tdata,   // action[2:0], timer_index[5:3], pad
    output ptb_pkg::cmd_beat_t           push,
    input  logic                         push_ready
);
    import ptb_pkg::*;

    logic [ACTION_W-1:0] action;
    logic [IDX_W-1:0]    idx;
    logic                idx_ok;
    logic                needs_idx;
    logic                beat;

    assign action = s_tdata[ACTION_W-1:0];
    assign idx    = s_tdata[ACTION_W+IDX_W-1:ACTION_W];
    assign beat   = s_tvalid && s_tready;

    // Tick and the all-timer actions ignore the index.
    always_comb
    begin
        case (action)
            ACT_TICK, ACT_START_ALL, ACT_STOP_ALL: needs_idx = 1'b0;
            default:                               needs_idx = 1'b1;
        endcase
    end

    assign idx_ok   = (int'(idx) < NUM_TIMERS);
    assign s_tready = push_ready;

    // Commands that address a timer which does not exist are dropped here.
    always_comb
    begin
        push.valid      = beat && (idx_ok || !needs_idx);
        push.cmd.action = action;
        push.cmd.idx    = needs_idx ? idx : '0;
    end

endmodule

[src/ptb_fifo.sv]
module ptb_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  ptb_pkg::cmd_beat_t push,
    output logic               push_ready,
    output ptb_pkg::cmd_beat_t head,
    input  logic               pop
);
    import ptb_pkg::*;

    cmd_t                 mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW:0]     count_reg;
    logic                 do_push;
    logic                 do_pop;

    assign push_ready = (count_reg != FIFO_AW'(0) + (FIFO_AW+1)'(FIFO_DEPTH));
    assign do_push    = push.valid && push_ready;
    assign do_pop     = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.cmd   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[src/ptb_back.sv]
module ptb_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ptb_pkg::cmd_beat_t            head,
    output logic                          pop,
    input  logic                          cfg_we,
    input  logic [ptb_pkg::IDX_W-1:0]     cfg_index,
    input  logic [ptb_pkg::LIMIT_W-1:0]   cfg_data,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ptb_pkg::OUT_DATA_W-1:0] m_tdata
);
    import ptb_pkg::*;

    tick_t  tick_now_reg;
    tick_t  start_reg   [NUM_TIMERS];
    tick_t  total_reg   [NUM_TIMERS];
    tick_t  begin_reg   [NUM_TIMERS];
    logic   paused_reg  [NUM_TIMERS];
    logic   active_reg  [NUM_TIMERS];
    limit_t limit_reg   [NUM_TIMERS];

    logic                 out_valid_reg;
    logic [ELAPSED_W-1:0] out_elapsed_reg;
    logic                 out_expired_reg;
    logic                 out_active_reg;
    logic                 out_paused_reg;

    cmd_t   cmd;
    tick_t  elapsed;
    limit_t q_limit;
    logic   expired;
    logic   is_query;

    assign cmd      = head.cmd;
    assign is_query = (cmd.action == ACT_QUERY);
    assign pop      = head.valid && (!is_query || !out_valid_reg || m_tready);

    // Elapsed time excludes only completed pauses.
    assign elapsed = tick_now_reg - start_reg[cmd.idx] - total_reg[cmd.idx];
    assign q_limit = limit_reg[cmd.idx];
    assign expired = q_limit[LIMIT_W-1] ||
                     ({1'b0, elapsed} > q_limit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                limit_reg[i] <= '1;
            end
        end
        else if (cfg_we && (int'(cfg_index) < NUM_TIMERS))
        begin
            limit_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_now_reg <= '0;
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                start_reg[i]  <= '0;
                total_reg[i]  <= '0;
                begin_reg[i]  <= '0;
                paused_reg[i] <= 1'b0;
                active_reg[i] <= 1'b0;
            end
        end
        else if (pop)
        begin
            case (cmd.action)
                ACT_TICK:
                begin
                    tick_now_reg <= tick_now_reg + 1'b1;
                end
                ACT_START:
                begin
                    start_reg[cmd.idx]  <= tick_now_reg;
                    total_reg[cmd.idx]  <= '0;
                    active_reg[cmd.idx] <= 1'b1;
                end
                ACT_STOP:
                begin
                    total_reg[cmd.idx]  <= '0;
                    active_reg[cmd.idx] <= 1'b0;
                end
                ACT_START_ALL:
                begin
                    for (int i = 0; i < NUM_TIMERS; i++)
                    begin
                        start_reg[i]  <= tick_now_reg;
                        total_reg[i]  <= '0;
                        active_reg[i] <= 1'b1;
                    end
                end
                ACT_STOP_ALL:
                begin
                    for (int i = 0; i < NUM_TIMERS; i++)
                    begin
                        total_reg[i]  <= '0;
                        active_reg[i] <= 1'b0;
                    end
                end
                ACT_PAUSE:
                begin
                    if (!paused_reg[cmd.idx])
                    begin
                        begin_reg[cmd.idx]  <= tick_now_reg;
                        paused_reg[cmd.idx] <= 1'b1;
                    end
                end
                ACT_RESUME:
                begin
                    if (paused_reg[cmd.idx])
                    begin
                        total_reg[cmd.idx]  <= total_reg[cmd.idx] +
                                               (tick_now_reg - begin_reg[cmd.idx]);
                        paused_reg[cmd.idx] <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result register: a query is popped only when this slot is free or
    // draining in the same cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop && is_query)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && is_query)
        begin
            out_elapsed_reg <= elapsed[ELAPSED_W-1:0];
            out_expired_reg <= expired;
            out_active_reg  <= active_reg[cmd.idx];
            out_paused_reg  <= paused_reg[cmd.idx];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_paused_reg, out_active_reg, out_expired_reg,
                       out_elapsed_reg};

endmodule

[src/pausable_timer_bank.sv]
// Bank of eight stopwatch timers whose time base is a stream of tick beats.
//
// Input stream (s_tvalid/s_tready/s_tdata): each beat carries an action and
// a timer index. Actions are tick, start, stop, start all, stop all, pause,
// resume and query. Only a query produces an output beat.
// Output stream (m_tvalid/m_tready/m_tdata): elapsed ticks, the expired flag
// and the timer's active and paused flags.
// Configuration: cfg_we writes cfg_data into the expiry limit selected by
// cfg_index; a negative limit means the timer is always expired.
//
// A front stage decodes beats into a four-entry command queue; the back
// stage executes one command per cycle, so the sustained rate is one beat
// per clock while no query waits for the result slot. A query's beat is
// queued, then its result is registered in the output register that drives
// m_tvalid. That register holds a result while the receiver stalls; other
// commands keep executing behind it, and a query waits in the queue until
// the result slot frees. When the queue is full, s_tready drops.
// Reset clears the tick count, all timer state and the queue, and sets all
// limits to -1.
module pausable_timer_bank (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ptb_pkg::IN_DATA_W-1:0]  s_tdata,   // action[2:0], timer_index[5:3], zero pad
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ptb_pkg::OUT_DATA_W-1:0] m_tdata,   // elapsed_ticks[31:0], expired[32],
                                                      // active[33], paused[34], zero pad
    input  logic                           cfg_we,
    input  logic [ptb_pkg::IDX_W-1:0]      cfg_index,
    input  logic [ptb_pkg::LIMIT_W-1:0]    cfg_data
);
    import ptb_pkg::*;

    cmd_beat_t push;
    cmd_beat_t head;
    logic      push_ready;
    logic      pop;

    // Decode and filter incoming beats.
    ptb_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push       (push),
        .push_ready (push_ready)
    );

    // Short queue that decouples the input side from result stalls.
    ptb_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .head       (head),
        .pop        (pop)
    );

    // Timer state, limits and the result register.
    ptb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

[tb/sv/testbench.sv]
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import ptb_pkg::*;

    // Width of the packed report fields at the bottom of m_tdata.
    localparam int REPORT_W = ELAPSED_W + 3;

    // A limit with the sign bit set marks a timer as always expired.
    localparam limit_t LIMIT_ALWAYS = '1;
    localparam limit_t LIMIT_MAX    = {1'b0, {TICK_WIDTH{1'b1}}};

    // Cycles without any beat or register write before the run is declared hung.
    // The longest legal quiet stretch is the receiver hold-off, so this leaves
    // a wide margin.
    localparam int HANG_LIMIT = 4000;

    // Cycles to let pass after the last report, so that commands that produce
    // no report can drain out of the four-entry queue and the back stage.
    localparam int SETTLE_CYCLES = 12;

    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 100;

    // One query report, laid out exactly as it sits in m_tdata[34:0]:
    // elapsed ticks in the low bits, then expired, active and paused.
    typedef struct packed {
        logic          paused;
        logic          active;
        logic          expired;
        logic [ELAPSED_W-1:0] elapsed;
    } timer_report_t;

    // The scoreboard keeps its own copy of the timer bank. Every accepted
    // command beat is applied to that copy; a query pushes the report it should
    // produce, and every output beat is checked against the oldest one.
    class report_scoreboard;
        tick_t         tick_now;
        tick_t         start_stamp [NUM_TIMERS];
        tick_t         pause_total [NUM_TIMERS];
        tick_t         pause_begin [NUM_TIMERS];
        bit            paused      [NUM_TIMERS];
        bit            active      [NUM_TIMERS];
        limit_t        limit       [NUM_TIMERS];
        timer_report_t expected_reports [$];
        int unsigned   mismatches;

        function new();
            tick_now = '0;
            for (int t = 0; t < NUM_TIMERS; t++)
            begin
                start_stamp[t] = '0;
                pause_total[t] = '0;
                pause_begin[t] = '0;
                paused[t]      = 1'b0;
                active[t]      = 1'b0;
                limit[t]       = LIMIT_ALWAYS;
            end
            mismatches = 0;
        endfunction

        function void set_limit(int idx, limit_t value);
            if (idx < NUM_TIMERS)
                limit[idx] = value;
        endfunction

        function void launch(int t);
            active[t]      = 1'b1;
            pause_total[t] = '0;
            start_stamp[t] = tick_now;
        endfunction

        function void halt(int t);
            active[t]      = 1'b0;
            pause_total[t] = '0;
        endfunction

        function void note_command(logic [ACTION_W-1:0] action, logic [IDX_W-1:0] idx);
            timer_report_t rep;
            tick_t         elapsed;
            bit            present;
            present = (int'(idx) < NUM_TIMERS);
            case (action)
                ACT_TICK:      tick_now = tick_now + 1'b1;
                ACT_START:     if (present) launch(idx);
                ACT_STOP:      if (present) halt(idx);
                ACT_START_ALL: for (int t = 0; t < NUM_TIMERS; t++) launch(t);
                ACT_STOP_ALL:  for (int t = 0; t < NUM_TIMERS; t++) halt(t);
                ACT_PAUSE:
                begin
                    if (present && !paused[idx])
                    begin
                        pause_begin[idx] = tick_now;
                        paused[idx]      = 1'b1;
                    end
                end
                ACT_RESUME:
                begin
                    if (present && paused[idx])
                    begin
                        pause_total[idx] = pause_total[idx] + (tick_now - pause_begin[idx]);
                        paused[idx]      = 1'b0;
                    end
                end
                ACT_QUERY:
                begin
                    if (present)
                    begin
                        // A pause still running is not subtracted here.
                        elapsed     = tick_now - start_stamp[idx] - pause_total[idx];
                        rep.elapsed = elapsed;
                        rep.expired = limit[idx][LIMIT_W-1] ||
                                      (elapsed > limit[idx][TICK_WIDTH-1:0]);
                        rep.active  = active[idx];
                        rep.paused  = paused[idx];
                        expected_reports.push_back(rep);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_report(logic [OUT_DATA_W-1:0] data);
            timer_report_t want;
            timer_report_t got;
            got = data[REPORT_W-1:0];
            if (expected_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: report beat with none expected: %s%0h %0b %0b %0b",
                             $realtime, "elapsed/exp/act/pau=",
                             got.elapsed, got.expired, got.active, got.paused);
                return;
            end
            want = expected_reports.pop_front();
            if (got.elapsed !== want.elapsed || got.expired !== want.expired ||
                got.active !== want.active || got.paused !== want.paused ||
                data[OUT_DATA_W-1:REPORT_W] !== '0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: report mismatch: expected elapsed=%0h exp=%0b act=%0b pau=%0b",
                             $realtime, want.elapsed, want.expired, want.active, want.paused);
                    $display("    got elapsed=%0h exp=%0b act=%0b pau=%0b pad=%0h",
                             got.elapsed, got.expired, got.active, got.paused,
                             data[OUT_DATA_W-1:REPORT_W]);
                end
            end
        endfunction

        function int outstanding();
            return expected_reports.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;     // action[2:0], timer_index[5:3], zero pad
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;     // elapsed_ticks[31:0], expired[32], active[33],
                                        // paused[34], zero pad
    logic                  cfg_we;
    logic [IDX_W-1:0]      cfg_index;
    logic [LIMIT_W-1:0]    cfg_data;

    report_scoreboard sb;

    // Sender pacing: a burst of back-to-back beats, then a gap of up to
    // gap_max cycles. A gap_max of zero gives an uninterrupted stream.
    int burst_left = 0;
    int gap_max    = 0;

    // Receiver pacing: ready_mode picks a stall pattern, and a nonzero
    // hold_off holds m_tready low for that many cycles first.
    int ready_mode  = 0;
    int hold_off    = 0;
    int ready_count = 0;

    int quiet_cycles = 0;

    limit_t limit_plan [NUM_TIMERS];

    pausable_timer_bank dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Beats are taken at the rising edge, where both sides see the values that
    // were driven at the falling edge before. The same process watches for a
    // hang: a long run of cycles with no beat and no register write.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_command(s_tdata[ACTION_W-1:0],
                                s_tdata[ACTION_W+IDX_W-1:ACTION_W]);
            if (m_tvalid && m_tready)
                sb.check_report(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= HANG_LIMIT)
            begin
                $display("timeout: no beat for %0d cycles", HANG_LIMIT);
                $display("pausable_timer_bank regression: fail");
                $finish;
            end
        end
    end

    // The receiver. Mode 0 is always ready, modes 1 and 2 stall rarely or
    // often at random, and mode 3 follows a periodic pattern taken from
    // ready_count. A hold-off overrides all of them.
    always @(negedge clk)
    begin
        ready_count++;
        if (hold_off > 0)
        begin
            m_tready <= 1'b0;
            hold_off--;
        end
        else
        begin
            case (ready_mode)
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                3:       m_tready <= ((ready_count % 11) < 6);
                default: m_tready <= 1'b1;
            endcase
        end
    end

    // Present one command beat and return at the falling edge after it was
    // taken. s_tvalid is left high, so a following call continues the burst.
    task automatic offer(input logic [ACTION_W-1:0] action, input logic [IDX_W-1:0] idx);
        s_tdata  <= {{(IN_DATA_W - ACTION_W - IDX_W){1'b0}}, idx, action};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drop valid for a number of cycles while random junk sits on the bus.
    task automatic idle_sender(input int cycles);
        if (cycles > 0)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= {{(IN_DATA_W - ACTION_W - IDX_W){1'b0}},
                         IDX_W'($urandom), ACTION_W'($urandom)};
            repeat (cycles) @(negedge clk);
        end
    endtask

    task automatic offer_paced(input logic [ACTION_W-1:0] action, input logic [IDX_W-1:0] idx);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if (gap_max > 0)
                idle_sender($urandom_range(0, gap_max));
        end
        burst_left--;
        offer(action, idx);
    endtask

    // Stop sending, wait for every outstanding report, then let the queue
    // finish any commands that produce none.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write all eight limits from limit_plan, one register per cycle.
    task automatic program_limits();
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= IDX_W'(i);
            cfg_data  <= limit_plan[i];
            sb.set_limit(i, limit_plan[i]);
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic limit_t choose_limit();
        case ($urandom_range(0, 5))
            0:       return LIMIT_ALWAYS;
            1:       return '0;
            2:       return LIMIT_MAX;
            3:       return limit_t'($urandom_range(0, 40));
            4:       return limit_t'($urandom_range(1, 400));
            default: return {1'b0, 32'($urandom)};
        endcase
    endfunction

    // Ticks and queries dominate so that elapsed counts grow and get compared
    // against the small limits; the all-timer actions are kept rare so that
    // individual timers drift apart.
    function automatic logic [ACTION_W-1:0] choose_action();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            return ACT_TICK;
        else if (pick < 60)
            return ACT_QUERY;
        else if (pick < 70)
            return ACT_START;
        else if (pick < 77)
            return ACT_STOP;
        else if (pick < 86)
            return ACT_PAUSE;
        else if (pick < 95)
            return ACT_RESUME;
        else if (pick < 98)
            return ACT_START_ALL;
        else
            return ACT_STOP_ALL;
    endfunction

    initial
    begin
        sb        = new();
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, with every limit still at its reset value of -1.
        // A timer that was never started reports the raw tick count.
        offer(ACT_QUERY, 3'd0);
        offer(ACT_TICK, 3'd0);
        offer(ACT_TICK, 3'd5);
        offer(ACT_QUERY, 3'd7);
        // Start, run two ticks, and read back.
        offer(ACT_START, 3'd0);
        offer(ACT_TICK, 3'd0);
        offer(ACT_TICK, 3'd0);
        offer(ACT_QUERY, 3'd0);
        // A second pause is ignored, and a query inside the pause still
        // counts the paused ticks.
        offer(ACT_PAUSE, 3'd0);
        offer(ACT_PAUSE, 3'd0);
        offer(ACT_TICK, 3'd0);
        offer(ACT_TICK, 3'd0);
        offer(ACT_QUERY, 3'd0);
        // The resume takes the pause off; a second resume is ignored.
        offer(ACT_RESUME, 3'd0);
        offer(ACT_RESUME, 3'd0);
        offer(ACT_QUERY, 3'd0);
        // All-timer actions, and a query on a stopped timer.
        offer(ACT_START_ALL, 3'd6);
        offer(ACT_TICK, 3'd0);
        offer(ACT_STOP, 3'd3);
        offer(ACT_QUERY, 3'd3);
        offer(ACT_STOP_ALL, 3'd1);
        // Restarting a paused timer keeps the old pause-begin stamp, so the
        // resume subtracts more than has elapsed and the count wraps to all ones.
        offer(ACT_PAUSE, 3'd1);
        offer(ACT_TICK, 3'd0);
        offer(ACT_START, 3'd1);
        offer(ACT_RESUME, 3'd1);
        offer(ACT_QUERY, 3'd1);

        // Random phases. Each starts from an idle block with a new set of
        // limits; the first phase uses the extremes and checks three of them
        // directly against the counts left by the directed part.
        for (int phase = 1; phase <= RANDOM_PHASES; phase++)
        begin
            drain();
            if (phase == 1)
                limit_plan = '{LIMIT_ALWAYS, limit_t'(0), LIMIT_MAX, limit_t'(1),
                               limit_t'(5), LIMIT_ALWAYS, LIMIT_MAX, limit_t'(2)};
            else
                for (int i = 0; i < NUM_TIMERS; i++)
                    limit_plan[i] = choose_limit();
            program_limits();

            // Every fourth phase is a clean stretch: no sender gaps and a
            // receiver that never stalls.
            ready_mode = phase % 4;
            gap_max    = (phase % 4 == 0) ? 0 : $urandom_range(2, 8);
            burst_left = 0;

            if (phase == 1)
            begin
                offer(ACT_QUERY, 3'd1);
                offer(ACT_QUERY, 3'd0);
                offer(ACT_QUERY, 3'd6);
            end

            // In the third phase the receiver holds off for a long stretch
            // while the sender streams without gaps, so the result slot and
            // the command queue fill and s_tready has to drop.
            if (phase == 3)
            begin
                hold_off = 250;
                gap_max  = 0;
            end

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                offer_paced(choose_action(), IDX_W'($urandom_range(0, NUM_TIMERS - 1)));
        end

        drain();
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("pausable_timer_bank regression: pass");
        else
            $display("pausable_timer_bank regression: fail");
        $finish;
    end

endmodule

[filelist.f]
src/ptb_pkg.sv
src/ptb_front.sv
src/ptb_fifo.sv
src/ptb_back.sv
src/pausable_timer_bank.sv
tb/sv/testbench.sv
